[hdl/dpcr_pkg.sv]
// Shared types, constants and helpers for the disk pair collision resolver.
// Used by every module of the block; depends on nothing else.
package dpcr_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int DATA_W        = 32;
	localparam int CD_W          = 31;
	localparam logic [CD_W-1:0] CD_RESET = 31'd655360;
	localparam int DISTSQ_W      = 62;
	localparam int ROOT_W        = 31;
	localparam int Q_DEPTH       = 4;
	localparam int Q_PTR_W       = 2;
	localparam int Q_CNT_W       = 3;

	typedef struct packed {
		logic signed [DATA_W-1:0] a_pos_x;
		logic signed [DATA_W-1:0] a_pos_y;
		logic signed [DATA_W-1:0] a_vel_x;
		logic signed [DATA_W-1:0] a_vel_y;
		logic signed [DATA_W-1:0] b_pos_x;
		logic signed [DATA_W-1:0] b_pos_y;
		logic signed [DATA_W-1:0] b_vel_x;
		logic signed [DATA_W-1:0] b_vel_y;
	} pair_t;

	typedef struct packed {
		pair_t                  pair;
		logic                   cand;
		logic [DISTSQ_W-1:0]    distsq;
		logic [CD_W-1:0]        dxm;
		logic [CD_W-1:0]        dym;
		logic                   dxs;
		logic                   dys;
		logic signed [DATA_W:0] rvx;
		logic signed [DATA_W:0] rvy;
		logic [CD_W-1:0]        cd;
	} job_t;

	typedef struct packed {
		logic  collided;
		pair_t pair;
	} res_t;

	function automatic logic signed [DATA_W-1:0] sat32(input logic signed [39:0] v);
		logic signed [39:0] hi;
		logic signed [39:0] lo;
		hi = 40'sd2147483647;
		lo = -40'sd2147483648;
		if (v > hi) begin
			sat32 = 32'sh7FFFFFFF;
		end else if (v < lo) begin
			sat32 = 32'sh80000000;
		end else begin
			sat32 = v[DATA_W-1:0];
		end
	endfunction

endpackage

[hdl/dpcr_front.sv]
// Front end: takes requests, forms differences, squares and the contact test.
// Depends on dpcr_pkg; feeds dpcr_fifo.
module dpcr_front import dpcr_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  pair_t           in_pair,
	input  logic [CD_W-1:0] cd,
	output logic            out_valid,
	input  logic            out_ready,
	output job_t            out_job
);

	logic                   en;
	logic                   v_s1, v_s2;
	pair_t                  pair_s1, pair_s2;
	logic signed [DATA_W:0] dx_s1, dy_s1, rvx_s1, rvy_s1, rvx_s2, rvy_s2;
	logic [CD_W-1:0]        cd_s1, cd_s2;
	logic [DATA_W:0]        dxm_c, dym_c;
	logic                   inr_c;
	logic [CD_W-1:0]        dxm_s2, dym_s2;
	logic                   dxs_s2, dys_s2, inr_s2;
	logic [DISTSQ_W-1:0]    sqx_s2, sqy_s2, cdsq_s2;
	logic [DISTSQ_W:0]      sum_c;

	assign en       = !v_s2 || out_ready;
	assign in_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
		end
	end

	always_comb begin
		dxm_c = dx_s1[DATA_W] ? -dx_s1 : dx_s1;
		dym_c = dy_s1[DATA_W] ? -dy_s1 : dy_s1;
		inr_c = (dxm_c <= {2'b00, cd_s1}) && (dym_c <= {2'b00, cd_s1});
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pair_s1 <= in_pair;
			cd_s1   <= cd;
			dx_s1   <= 33'(in_pair.a_pos_x) - 33'(in_pair.b_pos_x);
			dy_s1   <= 33'(in_pair.a_pos_y) - 33'(in_pair.b_pos_y);
			rvx_s1  <= 33'(in_pair.a_vel_x) - 33'(in_pair.b_vel_x);
			rvy_s1  <= 33'(in_pair.a_vel_y) - 33'(in_pair.b_vel_y);
			pair_s2 <= pair_s1;
			cd_s2   <= cd_s1;
			rvx_s2  <= rvx_s1;
			rvy_s2  <= rvy_s1;
			dxm_s2  <= dxm_c[CD_W-1:0];
			dym_s2  <= dym_c[CD_W-1:0];
			dxs_s2  <= dx_s1[DATA_W];
			dys_s2  <= dy_s1[DATA_W];
			inr_s2  <= inr_c;
			sqx_s2  <= dxm_c[CD_W-1:0] * dxm_c[CD_W-1:0];
			sqy_s2  <= dym_c[CD_W-1:0] * dym_c[CD_W-1:0];
			cdsq_s2 <= cd_s1 * cd_s1;
		end
	end

	always_comb begin
		sum_c          = {1'b0, sqx_s2} + {1'b0, sqy_s2};
		out_job.pair   = pair_s2;
		out_job.cand   = inr_s2 && (sum_c != '0) && (sum_c <= {1'b0, cdsq_s2});
		out_job.distsq = sum_c[DISTSQ_W-1:0];
		out_job.dxm    = dxm_s2;
		out_job.dym    = dym_s2;
		out_job.dxs    = dxs_s2;
		out_job.dys    = dys_s2;
		out_job.rvx    = rvx_s2;
		out_job.rvy    = rvy_s2;
		out_job.cd     = cd_s2;
	end

	assign out_valid = v_s2;

endmodule

[hdl/dpcr_fifo.sv]
// Short request queue between the front end and the back end.
// Depends on dpcr_pkg for the job type and depth.
module dpcr_fifo import dpcr_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  job_t  in_job,
	output logic  out_valid,
	input  logic  out_ready,
	output job_t  out_job
);

	job_t               mem_q [Q_DEPTH];
	logic [Q_PTR_W-1:0] wr_q, rd_q;
	logic [Q_CNT_W-1:0] cnt_q;
	logic               push, pop;

	assign in_ready  = (cnt_q != Q_CNT_W'(Q_DEPTH));
	assign out_valid = (cnt_q != '0);
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;
	assign out_job   = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop)  rd_q <= rd_q + 1'b1;
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= in_job;
	end

endmodule

[hdl/dpcr_back.sv]
// Back end: pipelined square root, two pipelined divides, impulse and push-out.
// Depends on dpcr_pkg; takes jobs from dpcr_fifo.
module dpcr_back import dpcr_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  job_t in_job,
	output logic out_valid,
	input  logic out_ready,
	output res_t out_res
);

	localparam int REM_W = ROOT_W + 3;
	localparam int DIV_N = FRAC_BITS + 1;
	localparam int NW    = FRAC_BITS + 2;
	localparam int PW    = FRAC_BITS + 35;
	localparam int VW    = 36;
	localparam int CW    = 34;
	localparam int IW    = 38;

	logic en;

	logic              sv_q    [ROOT_W];
	job_t              sj_q    [ROOT_W];
	logic [REM_W-1:0]  srem_q  [ROOT_W];
	logic [ROOT_W-1:0] sroot_q [ROOT_W];

	logic              dv_q  [DIV_N];
	job_t              dj_q  [DIV_N];
	logic [ROOT_W-1:0] dd_q  [DIV_N];
	logic [ROOT_W-1:0] drx_q [DIV_N];
	logic [ROOT_W-1:0] dry_q [DIV_N];
	logic [DIV_N-1:0]  dqx_q [DIV_N];
	logic [DIV_N-1:0]  dqy_q [DIV_N];

	logic v_s1, v_s2, v_s3, v_s4;

	assign en       = !v_s4 || out_ready;
	assign in_ready = en;

	genvar k;
	generate
		for (k = 0; k < ROOT_W; k++) begin : g_sqrt
			logic              v_i;
			job_t              j_i;
			logic [REM_W-1:0]  rem_i, rsh, trial;
			logic [ROOT_W-1:0] root_i;
			logic              ge;
			if (k == 0) begin : g_first
				assign v_i    = in_valid;
				assign j_i    = in_job;
				assign rem_i  = '0;
				assign root_i = '0;
			end else begin : g_next
				assign v_i    = sv_q[k-1];
				assign j_i    = sj_q[k-1];
				assign rem_i  = srem_q[k-1];
				assign root_i = sroot_q[k-1];
			end
			assign rsh   = {rem_i[REM_W-3:0], j_i.distsq[DISTSQ_W-1-2*k -: 2]};
			assign trial = {1'b0, root_i, 2'b01};
			assign ge    = rsh >= trial;
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					sv_q[k] <= 1'b0;
				end else if (en) begin
					sv_q[k] <= v_i;
				end
			end
			always_ff @(posedge clk) begin
				if (en) begin
					sj_q[k]    <= j_i;
					srem_q[k]  <= ge ? (rsh - trial) : rsh;
					sroot_q[k] <= {root_i[ROOT_W-2:0], ge};
				end
			end
		end

		for (k = 0; k < DIV_N; k++) begin : g_div
			logic              v_i;
			job_t              j_i;
			logic [ROOT_W-1:0] d_i, rx_i, ry_i;
			logic [DIV_N-1:0]  qx_i, qy_i;
			logic              bx, by, gex, gey;
			logic [ROOT_W:0]   tx, ty;
			if (k == 0) begin : g_first
				assign v_i  = sv_q[ROOT_W-1];
				assign j_i  = sj_q[ROOT_W-1];
				assign d_i  = sroot_q[ROOT_W-1];
				assign rx_i = {1'b0, j_i.dxm[CD_W-1:1]};
				assign ry_i = {1'b0, j_i.dym[CD_W-1:1]};
				assign qx_i = '0;
				assign qy_i = '0;
				assign bx   = j_i.dxm[0];
				assign by   = j_i.dym[0];
			end else begin : g_next
				assign v_i  = dv_q[k-1];
				assign j_i  = dj_q[k-1];
				assign d_i  = dd_q[k-1];
				assign rx_i = drx_q[k-1];
				assign ry_i = dry_q[k-1];
				assign qx_i = dqx_q[k-1];
				assign qy_i = dqy_q[k-1];
				assign bx   = 1'b0;
				assign by   = 1'b0;
			end
			assign tx  = {rx_i, bx};
			assign ty  = {ry_i, by};
			assign gex = tx >= {1'b0, d_i};
			assign gey = ty >= {1'b0, d_i};
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					dv_q[k] <= 1'b0;
				end else if (en) begin
					dv_q[k] <= v_i;
				end
			end
			always_ff @(posedge clk) begin
				if (en) begin
					dj_q[k]  <= j_i;
					dd_q[k]  <= d_i;
					drx_q[k] <= gex ? ROOT_W'(tx - {1'b0, d_i}) : tx[ROOT_W-1:0];
					dry_q[k] <= gey ? ROOT_W'(ty - {1'b0, d_i}) : ty[ROOT_W-1:0];
					dqx_q[k] <= {qx_i[DIV_N-2:0], gex};
					dqy_q[k] <= {qy_i[DIV_N-2:0], gey};
				end
			end
		end
	endgenerate

	job_t               j_d, j_s1, j_s2, j_s3;
	logic [DIV_N-1:0]   qx_d, qy_d;
	logic signed [NW-1:0] nx_c, ny_c, nx_s1, ny_s1, nx_s2, ny_s2;
	logic signed [DATA_W:0] pen_c;
	logic signed [PW-1:0] px_s1, py_s1, pcx_s1, pcy_s1;
	logic signed [PW:0]   psum_c;
	logic signed [VW-1:0] vn_s2;
	logic signed [CW-1:0] cx_s2, cy_s2, cx_s3, cy_s3;
	logic signed [VW+NW-1:0] ipx_c, ipy_c;
	logic signed [IW-1:0] ix_s3, iy_s3;
	logic                 hit_s3;
	res_t                 res_c, res_s4;

	assign j_d  = dj_q[DIV_N-1];
	assign qx_d = dqx_q[DIV_N-1];
	assign qy_d = dqy_q[DIV_N-1];

	always_comb begin
		nx_c  = j_d.dxs ? -$signed({1'b0, qx_d}) : $signed({1'b0, qx_d});
		ny_c  = j_d.dys ? -$signed({1'b0, qy_d}) : $signed({1'b0, qy_d});
		pen_c = $signed({2'b00, j_d.cd}) - $signed({2'b00, dd_q[DIV_N-1]});
	end

	assign psum_c = (PW+1)'(px_s1) + (PW+1)'(py_s1);
	assign ipx_c  = vn_s2 * nx_s2;
	assign ipy_c  = vn_s2 * ny_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= dv_q[DIV_N-1];
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			j_s1   <= j_d;
			nx_s1  <= nx_c;
			ny_s1  <= ny_c;
			px_s1  <= j_d.rvx * nx_c;
			py_s1  <= j_d.rvy * ny_c;
			pcx_s1 <= pen_c * nx_c;
			pcy_s1 <= pen_c * ny_c;
			j_s2   <= j_s1;
			nx_s2  <= nx_s1;
			ny_s2  <= ny_s1;
			vn_s2  <= $signed(psum_c[PW:FRAC_BITS]);
			cx_s2  <= $signed(pcx_s1[PW-1:FRAC_BITS+1]);
			cy_s2  <= $signed(pcy_s1[PW-1:FRAC_BITS+1]);
			j_s3   <= j_s2;
			cx_s3  <= cx_s2;
			cy_s3  <= cy_s2;
			ix_s3  <= $signed(ipx_c[VW+NW-1:FRAC_BITS]);
			iy_s3  <= $signed(ipy_c[VW+NW-1:FRAC_BITS]);
			hit_s3 <= j_s2.cand && (vn_s2[VW-1] || (vn_s2 == '0));
			res_s4 <= res_c;
		end
	end

	always_comb begin
		res_c.collided = hit_s3;
		res_c.pair     = j_s3.pair;
		if (hit_s3) begin
			res_c.pair.a_pos_x = sat32(40'(j_s3.pair.a_pos_x) + 40'(cx_s3));
			res_c.pair.a_pos_y = sat32(40'(j_s3.pair.a_pos_y) + 40'(cy_s3));
			res_c.pair.a_vel_x = sat32(40'(j_s3.pair.a_vel_x) - 40'(ix_s3));
			res_c.pair.a_vel_y = sat32(40'(j_s3.pair.a_vel_y) - 40'(iy_s3));
			res_c.pair.b_pos_x = sat32(40'(j_s3.pair.b_pos_x) - 40'(cx_s3));
			res_c.pair.b_pos_y = sat32(40'(j_s3.pair.b_pos_y) - 40'(cy_s3));
			res_c.pair.b_vel_x = sat32(40'(j_s3.pair.b_vel_x) + 40'(ix_s3));
			res_c.pair.b_vel_y = sat32(40'(j_s3.pair.b_vel_y) + 40'(iy_s3));
		end
	end

	assign out_valid = v_s4;
	assign out_res   = res_s4;

endmodule

[hdl/disk_pair_collision_resolve_top.sv]
// Top level of the equal-mass disk pair collision resolver.
// Depends on dpcr_pkg, dpcr_front, dpcr_fifo and dpcr_back.
//
// Usage:
//   s_axis carries one disk pair per request (positions and velocities,
//   signed fixed point); m_axis returns one result per request, in order,
//   with the collided flag on tuser and the eight updated fields on tdata.
//   cfg_wen/cfg_wdata write the contact distance; write it only while idle.
// Throughput: one request per cycle, sustained while m_axis_tready stays high.
// Pipeline: from accept to result a request passes through the 31 stages of the
//   square root and the FRAC_BITS + 1 stages of the normal divides.
// Reset: clears all pipeline and queue valid state and loads the contact
//   distance with 10.0.
// Stall: the back end holds while m_axis_tready is low and a result is waiting;
//   the front end keeps taking requests until the four-entry queue and its own
//   stages are full, and only then drops s_axis_tready.
module disk_pair_collision_resolve_top import dpcr_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_axis_tvalid,
	output logic             s_axis_tready,
	// a_pos_x, a_pos_y, a_vel_x, a_vel_y, b_pos_x, b_pos_y, b_vel_x, b_vel_y
	input  logic [255:0]     s_axis_tdata,
	output logic             m_axis_tvalid,
	input  logic             m_axis_tready,
	// new_a_pos_x, new_a_pos_y, new_a_vel_x, new_a_vel_y,
	// new_b_pos_x, new_b_pos_y, new_b_vel_x, new_b_vel_y
	output logic [255:0]     m_axis_tdata,
	// collided
	output logic             m_axis_tuser,
	input  logic             cfg_wen,
	input  logic [CD_W-1:0]  cfg_wdata
);

	logic [CD_W-1:0] cd_q;
	pair_t           in_pair;
	job_t            f_job, q_job;
	logic            f_valid, f_ready, q_valid, q_ready;
	res_t            res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cd_q <= CD_RESET;
		end else if (cfg_wen) begin
			cd_q <= cfg_wdata;
		end
	end

	always_comb begin
		in_pair.a_pos_x = s_axis_tdata[31:0];
		in_pair.a_pos_y = s_axis_tdata[63:32];
		in_pair.a_vel_x = s_axis_tdata[95:64];
		in_pair.a_vel_y = s_axis_tdata[127:96];
		in_pair.b_pos_x = s_axis_tdata[159:128];
		in_pair.b_pos_y = s_axis_tdata[191:160];
		in_pair.b_vel_x = s_axis_tdata[223:192];
		in_pair.b_vel_y = s_axis_tdata[255:224];
	end

	dpcr_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_pair   (in_pair),
		.cd        (cd_q),
		.out_valid (f_valid),
		.out_ready (f_ready),
		.out_job   (f_job)
	);

	dpcr_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (f_valid),
		.in_ready  (f_ready),
		.in_job    (f_job),
		.out_valid (q_valid),
		.out_ready (q_ready),
		.out_job   (q_job)
	);

	dpcr_back #(.FRAC_BITS(FRAC_BITS)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (q_valid),
		.in_ready  (q_ready),
		.in_job    (q_job),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_res   (res)
	);

	assign m_axis_tuser = res.collided;
	assign m_axis_tdata = {res.pair.b_vel_y, res.pair.b_vel_x, res.pair.b_pos_y,
		res.pair.b_pos_x, res.pair.a_vel_y, res.pair.a_vel_x, res.pair.a_pos_y,
		res.pair.a_pos_x};

endmodule
